// ===== sv/i2c_master_transaction_sequencer_core_defines.svh =====
// Assertion macros for the I2C master transaction sequencer core.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define I2CSEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2cseq assertion failed");
`define I2CSEQ_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("i2cseq assertion failed");
`else
`define I2CSEQ_ASSERT(label, clk, rst, prop)
`define I2CSEQ_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== sv/i2cseq_pkg.sv =====
// Types, codes and constants shared by the I2C master transaction sequencer.
package i2cseq_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_EVENT = 1'b1;

   localparam logic [1:0] OP_SEND_BYTE = 2'd0;
   localparam logic [1:0] OP_RECV_BYTE = 2'd1;
   localparam logic [1:0] OP_READ_N    = 2'd2;
   localparam logic [1:0] OP_WRITE_N   = 2'd3;

   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_ONE_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TWO_BYTE  = 2'd2;
   localparam logic [1:0] KIND_EIGHT_X   = 2'd3;

   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_READ  = 2'd1;
   localparam logic [1:0] PHASE_WRITE = 2'd2;

   localparam logic [1:0] END_BUSY     = 2'd0;
   localparam logic [1:0] END_DONE     = 2'd1;
   localparam logic [1:0] END_ERROR    = 2'd2;
   localparam logic [1:0] END_REJECTED = 2'd3;

   localparam logic [6:0] CTRL_AA  = 7'h04;
   localparam logic [6:0] CTRL_SI  = 7'h08;
   localparam logic [6:0] CTRL_STO = 7'h10;
   localparam logic [6:0] CTRL_STA = 7'h20;
   localparam logic [6:0] CTRL_EN  = 7'h40;

   localparam logic [7:0] STATUS_MASK = 8'hF8;
   localparam logic [7:0] READ_BIT_CLEAR = 8'hFE;

   localparam logic [7:0] ST_START         = 8'h08;
   localparam logic [7:0] ST_RESTART       = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK     = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK    = 8'h20;
   localparam logic [7:0] ST_DATA_TX_ACK   = 8'h28;
   localparam logic [7:0] ST_DATA_TX_NACK  = 8'h30;
   localparam logic [7:0] ST_ARB_LOST      = 8'h38;
   localparam logic [7:0] ST_SLA_R_ACK     = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK    = 8'h48;
   localparam logic [7:0] ST_DATA_RX_ACK   = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NACK  = 8'h58;

   typedef struct packed {
      logic        func;
      logic [1:0]  op;
      logic [7:0]  dev_addr;
      logic [1:0]  sub_kind;
      logic [15:0] sub_addr;
      logic [15:0] count;
      logic [7:0]  status;
      logic [7:0]  rx_data;
      logic [7:0]  tx_data;
   } req_type;

   typedef struct packed {
      logic       data_write;
      logic [7:0] data_byte;
      logic [6:0] ctrl_set;
      logic [6:0] ctrl_clear;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_taken;
      logic [1:0] end_state;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  addr_byte;
      logic [15:0] subaddress;
      logic [1:0]  sub_bytes_left;
      logic [1:0]  sub_phase;
      logic [1:0]  end_flag;
   } seq_state_type;

endpackage

// ===== sv/i2cseq_step.sv =====
// Decision logic for one transaction: result fields and next sequencer state.
module i2cseq_step #(
   parameter int COUNT_WIDTH = i2cseq_pkg::COUNT_WIDTH_DEFAULT
) (
   input  i2cseq_pkg::req_type       item,
   input  i2cseq_pkg::seq_state_type state_cur,
   input  logic [COUNT_WIDTH-1:0]    bytes_left_cur,
   output i2cseq_pkg::rsp_type       result,
   output i2cseq_pkg::seq_state_type state_nxt,
   output logic [COUNT_WIDTH-1:0]    bytes_left_nxt
);
   import i2cseq_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

   logic [31:0]            count_ext;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [7:0]             code;
   logic [7:0]             rbit;
   logic [COUNT_WIDTH-1:0] rx_left;

   assign count_ext = {16'b0, item.count};
   assign cnt       = count_ext[COUNT_WIDTH-1:0];
   assign code      = item.status & STATUS_MASK;
   assign rbit      = (item.op == OP_READ_N) ? 8'd1 : 8'd0;
   assign rx_left   = (bytes_left_cur != CNT_ZERO) ? bytes_left_cur - CNT_ONE : CNT_ZERO;

   always_comb begin
      result         = '0;
      state_nxt      = state_cur;
      bytes_left_nxt = bytes_left_cur;
      if (item.func == FUNC_START) begin
         if (item.op == OP_SEND_BYTE || item.op == OP_RECV_BYTE) begin
            state_nxt.addr_byte = item.dev_addr + {6'b0, item.op};
            bytes_left_nxt      = CNT_ONE;
            state_nxt.sub_phase = PHASE_NONE;
            state_nxt.end_flag  = END_BUSY;
            result.ctrl_clear   = CTRL_STA | CTRL_SI | CTRL_AA;
            result.ctrl_set     = CTRL_EN | CTRL_STA;
            result.end_state    = END_BUSY;
         end else if (cnt == CNT_ZERO || item.sub_kind == KIND_NONE) begin
            result.end_state = END_REJECTED;
         end else begin
            if (item.sub_kind == KIND_EIGHT_X) begin
               state_nxt.addr_byte = item.dev_addr + {4'b0, item.sub_addr[10:8], 1'b0} + rbit;
               state_nxt.subaddress     = {8'b0, item.sub_addr[7:0]};
               state_nxt.sub_bytes_left = 2'd1;
            end else begin
               state_nxt.addr_byte      = item.dev_addr + rbit;
               state_nxt.subaddress     = item.sub_addr;
               state_nxt.sub_bytes_left = item.sub_kind;
            end
            bytes_left_nxt      = cnt;
            state_nxt.sub_phase = (item.op == OP_READ_N) ? PHASE_READ : PHASE_WRITE;
            state_nxt.end_flag  = END_BUSY;
            result.ctrl_clear   = CTRL_STA | CTRL_SI | CTRL_AA;
            result.ctrl_set     = CTRL_EN | CTRL_STA;
            result.end_state    = END_BUSY;
         end
      end else begin
         case (code)
            ST_START: begin
               result.data_write = 1'b1;
               result.data_byte  = (state_cur.sub_phase == PHASE_READ) ?
                                   (state_cur.addr_byte & READ_BIT_CLEAR) : state_cur.addr_byte;
               result.ctrl_clear = CTRL_STA | CTRL_SI;
            end
            ST_RESTART: begin
               result.data_write = 1'b1;
               result.data_byte  = state_cur.addr_byte;
               result.ctrl_clear = CTRL_STA | CTRL_SI;
            end
            ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
               if (state_cur.sub_phase == PHASE_NONE) begin
                  result.ctrl_clear = CTRL_STA | CTRL_SI;
                  if (bytes_left_cur != CNT_ZERO) begin
                     result.data_write = 1'b1;
                     result.data_byte  = item.tx_data;
                     result.tx_taken   = 1'b1;
                     bytes_left_nxt    = bytes_left_cur - CNT_ONE;
                  end else begin
                     result.ctrl_set    = CTRL_STO;
                     state_nxt.end_flag = END_DONE;
                  end
               end else if (state_cur.sub_phase == PHASE_READ ||
                            state_cur.sub_phase == PHASE_WRITE) begin
                  if (state_cur.sub_bytes_left == 2'd2) begin
                     result.data_write        = 1'b1;
                     result.data_byte         = state_cur.subaddress[15:8];
                     result.ctrl_clear        = CTRL_STA | CTRL_SI;
                     state_nxt.sub_bytes_left = 2'd1;
                  end else if (state_cur.sub_bytes_left == 2'd1) begin
                     result.data_write        = 1'b1;
                     result.data_byte         = state_cur.subaddress[7:0];
                     result.ctrl_clear        = CTRL_STA | CTRL_SI;
                     state_nxt.sub_bytes_left = 2'd0;
                     if (state_cur.sub_phase == PHASE_WRITE) begin
                        state_nxt.sub_phase = PHASE_NONE;
                     end
                  end else if (state_cur.sub_bytes_left == 2'd0 &&
                               state_cur.sub_phase == PHASE_READ) begin
                     result.ctrl_set     = CTRL_STA;
                     result.ctrl_clear   = CTRL_SI;
                     state_nxt.sub_phase = PHASE_NONE;
                  end
               end
            end
            ST_SLA_R_ACK: begin
               if (bytes_left_cur <= CNT_ONE) begin
                  result.ctrl_clear = CTRL_STA | CTRL_SI | CTRL_AA;
               end else begin
                  result.ctrl_set   = CTRL_AA;
                  result.ctrl_clear = CTRL_STA | CTRL_SI;
               end
            end
            ST_SLA_W_NACK, ST_DATA_TX_NACK, ST_ARB_LOST, ST_SLA_R_NACK: begin
               result.ctrl_clear  = CTRL_STA | CTRL_SI;
               state_nxt.end_flag = END_ERROR;
            end
            ST_DATA_RX_ACK: begin
               result.rx_valid = 1'b1;
               result.rx_byte  = item.rx_data;
               bytes_left_nxt  = rx_left;
               if (rx_left == CNT_ONE) begin
                  result.ctrl_clear = CTRL_STA | CTRL_SI | CTRL_AA;
               end else begin
                  result.ctrl_set   = CTRL_AA;
                  result.ctrl_clear = CTRL_STA | CTRL_SI;
               end
            end
            ST_DATA_RX_NACK: begin
               result.rx_valid    = 1'b1;
               result.rx_byte     = item.rx_data;
               result.ctrl_set    = CTRL_STO;
               result.ctrl_clear  = CTRL_STA | CTRL_SI;
               state_nxt.end_flag = END_DONE;
            end
            default: begin
            end
         endcase
         result.end_state = state_nxt.end_flag;
      end
   end

endmodule

// ===== sv/i2c_master_transaction_sequencer_core.sv =====
// A transaction accepted on req is held in the input register, passes through the decision
// stage into the result register and drives rsp from there; one transaction per cycle is
// taken while rsp is ready, with the sequencer state updated in the decision stage.
// A stalled result holds in the result register while the input register takes one more.
// Reset is synchronous and active high; it empties both stages and clears the
// sequencer state to zero (no sub-address pending, busy).
module i2c_master_transaction_sequencer_core #(
   parameter int COUNT_WIDTH = i2cseq_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cseq_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cseq_pkg::rsp_type rsp_data
);
   import i2cseq_pkg::*;

`include "i2c_master_transaction_sequencer_core_defines.svh"

   req_type                in_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   seq_state_type          state_ff;
   seq_state_type          state_in;
   logic [COUNT_WIDTH-1:0] bytes_left_ff;
   logic [COUNT_WIDTH-1:0] bytes_left_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   advance;
   logic                   req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   i2cseq_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .item           (in_ff),
      .state_cur      (state_ff),
      .bytes_left_cur (bytes_left_ff),
      .result         (rsp_in),
      .state_nxt      (state_in),
      .bytes_left_nxt (bytes_left_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
         bytes_left_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff      <= state_in;
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `I2CSEQ_ASSERT_NORST(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid)
   `I2CSEQ_ASSERT(a_take_fills_stage, clock, reset, req_take |=> in_valid_ff)
   `I2CSEQ_ASSERT(a_drain_no_phantom, clock, reset, rsp_valid && rsp_ready && !in_valid_ff |=> !rsp_valid)
   `I2CSEQ_ASSERT(a_tx_needs_write, clock, reset, rsp_valid && rsp_data.tx_taken |-> rsp_data.data_write && !rsp_data.rx_valid)

endmodule

// ===== tb/tb_i2c_master_transaction_sequencer_core.sv =====
// Self-checking testbench for the I2C master transaction sequencer core.
module tb_i2c_master_transaction_sequencer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cseq_pkg::*;

   localparam int CW              = COUNT_WIDTH_DEFAULT;
   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_ITEMS    = 420;
   localparam int LIMIT_CYCLES    = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 10;
   localparam int MAX_REPORTS     = 200;

   localparam logic [6:0] CLR_START = CTRL_STA | CTRL_SI | CTRL_AA;
   localparam logic [6:0] CLR_NEXT  = CTRL_STA | CTRL_SI;
   localparam logic [6:0] SET_START = CTRL_EN | CTRL_STA;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [7:0]    sq_addr = '0;
   logic [15:0]   sq_sub = '0;
   logic [1:0]    sq_sub_left = '0;
   logic [1:0]    sq_phase = PHASE_NONE;
   logic [CW-1:0] sq_left = '0;
   logic [1:0]    sq_end = END_BUSY;

   rsp_type     rsp_due_q[$];
   dir_row_type dir_tab[$];
   rsp_type     want;
   int          failures = 0;
   int          reports = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          hold_off_req = 1'b0;
   bit          steady = 1'b0;

   i2c_master_transaction_sequencer_core #(.COUNT_WIDTH(CW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic rsp_type sequencer_response(input req_type r);
      rsp_type    o;
      logic [7:0] code;
      logic       rbit;
      o = '0;
      code = r.status & STATUS_MASK;
      if (r.func == FUNC_START) begin
         if (r.op == OP_SEND_BYTE || r.op == OP_RECV_BYTE) begin
            sq_addr = r.dev_addr + {6'd0, r.op};
            sq_left = CW'(1);
            sq_phase = PHASE_NONE;
            sq_end = END_BUSY;
            o.ctrl_clear = CLR_START;
            o.ctrl_set = SET_START;
            o.end_state = END_BUSY;
         end else if (r.count[CW-1:0] == '0 || r.sub_kind == KIND_NONE) begin
            o.end_state = END_REJECTED;
         end else begin
            rbit = (r.op == OP_READ_N);
            if (r.sub_kind == KIND_EIGHT_X) begin
               sq_addr = r.dev_addr + {4'd0, r.sub_addr[10:8], 1'b0} + {7'd0, rbit};
               sq_sub = {8'd0, r.sub_addr[7:0]};
               sq_sub_left = 2'd1;
            end else begin
               sq_addr = r.dev_addr + {7'd0, rbit};
               sq_sub = r.sub_addr;
               sq_sub_left = r.sub_kind;
            end
            sq_left = r.count[CW-1:0];
            sq_phase = rbit ? PHASE_READ : PHASE_WRITE;
            sq_end = END_BUSY;
            o.ctrl_clear = CLR_START;
            o.ctrl_set = SET_START;
            o.end_state = END_BUSY;
         end
      end else begin
         case (code)
            ST_START: begin
               o.data_write = 1'b1;
               o.data_byte = (sq_phase == PHASE_READ) ? (sq_addr & READ_BIT_CLEAR) : sq_addr;
               o.ctrl_clear = CLR_NEXT;
            end
            ST_RESTART: begin
               o.data_write = 1'b1;
               o.data_byte = sq_addr;
               o.ctrl_clear = CLR_NEXT;
            end
            ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
               case (sq_phase)
                  PHASE_NONE: begin
                     if (sq_left != '0) begin
                        o.data_write = 1'b1;
                        o.data_byte = r.tx_data;
                        o.tx_taken = 1'b1;
                        o.ctrl_clear = CLR_NEXT;
                        sq_left = sq_left - 1'b1;
                     end else begin
                        o.ctrl_set = CTRL_STO;
                        o.ctrl_clear = CLR_NEXT;
                        sq_end = END_DONE;
                     end
                  end
                  PHASE_READ: begin
                     if (sq_sub_left == 2'd2) begin
                        o.data_write = 1'b1;
                        o.data_byte = sq_sub[15:8];
                        o.ctrl_clear = CLR_NEXT;
                        sq_sub_left = 2'd1;
                     end else if (sq_sub_left == 2'd1) begin
                        o.data_write = 1'b1;
                        o.data_byte = sq_sub[7:0];
                        o.ctrl_clear = CLR_NEXT;
                        sq_sub_left = 2'd0;
                     end else if (sq_sub_left == 2'd0) begin
                        o.ctrl_set = CTRL_STA;
                        o.ctrl_clear = CTRL_SI;
                        sq_phase = PHASE_NONE;
                     end
                  end
                  PHASE_WRITE: begin
                     if (sq_sub_left == 2'd2) begin
                        o.data_write = 1'b1;
                        o.data_byte = sq_sub[15:8];
                        o.ctrl_clear = CLR_NEXT;
                        sq_sub_left = 2'd1;
                     end else if (sq_sub_left == 2'd1) begin
                        o.data_write = 1'b1;
                        o.data_byte = sq_sub[7:0];
                        o.ctrl_clear = CLR_NEXT;
                        sq_sub_left = 2'd0;
                        sq_phase = PHASE_NONE;
                     end
                  end
                  default: ;
               endcase
            end
            ST_SLA_R_ACK: begin
               if (sq_left <= 1) begin
                  o.ctrl_clear = CLR_START;
               end else begin
                  o.ctrl_set = CTRL_AA;
                  o.ctrl_clear = CLR_NEXT;
               end
            end
            ST_SLA_W_NACK, ST_DATA_TX_NACK, ST_ARB_LOST, ST_SLA_R_NACK: begin
               o.ctrl_clear = CLR_NEXT;
               sq_end = END_ERROR;
            end
            ST_DATA_RX_ACK: begin
               o.rx_valid = 1'b1;
               o.rx_byte = r.rx_data;
               if (sq_left != '0) sq_left = sq_left - 1'b1;
               if (sq_left == 1) begin
                  o.ctrl_clear = CLR_START;
               end else begin
                  o.ctrl_set = CTRL_AA;
                  o.ctrl_clear = CLR_NEXT;
               end
            end
            ST_DATA_RX_NACK: begin
               o.rx_valid = 1'b1;
               o.rx_byte = r.rx_data;
               o.ctrl_set = CTRL_STO;
               o.ctrl_clear = CLR_NEXT;
               sq_end = END_DONE;
            end
            default: ;
         endcase
         o.end_state = sq_end;
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type mk_start(input logic [1:0] op, input logic [7:0] dev,
                                        input logic [1:0] kind, input logic [15:0] sa,
                                        input logic [15:0] cnt);
      req_type r;
      r = '0;
      r.func = FUNC_START;
      r.op = op;
      r.dev_addr = dev;
      r.sub_kind = kind;
      r.sub_addr = sa;
      r.count = cnt;
      return r;
   endfunction

   function automatic req_type mk_event(input logic [7:0] status, input logic [7:0] rxd,
                                        input logic [7:0] txd);
      req_type r;
      r = '0;
      r.func = FUNC_EVENT;
      r.status = status;
      r.rx_data = rxd;
      r.tx_data = txd;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic dw, input logic [7:0] db,
                                      input logic [6:0] cs, input logic [6:0] cc,
                                      input logic rv, input logic [7:0] rb,
                                      input logic tt, input logic [1:0] es);
      rsp_type o;
      o.data_write = dw;
      o.data_byte = db;
      o.ctrl_set = cs;
      o.ctrl_clear = cc;
      o.rx_valid = rv;
      o.rx_byte = rb;
      o.tx_taken = tt;
      o.end_state = es;
      return o;
   endfunction

   function automatic logic [7:0] pick_error();
      case ($urandom_range(0, 3))
         0: return ST_SLA_W_NACK;
         1: return ST_DATA_TX_NACK;
         2: return ST_ARB_LOST;
         default: return ST_SLA_R_NACK;
      endcase
   endfunction

   task automatic add_row(input req_type r, input logic typed, input rsp_type o);
      dir_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = o;
      dir_tab.push_back(row);
   endtask

   // Entered and left at a falling edge; valid stays high between back-to-back transactions.
   task automatic send_item(input req_type r, input logic typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = (steady || hold_off_req) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = sequencer_response(r);
      rsp_due_q.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rsp_due_q.size() != 0) @(negedge clock);
   endtask

   task automatic send_event(input logic [7:0] code);
      req_type r;
      r.func = FUNC_EVENT;
      r.op = 2'($urandom);
      r.dev_addr = 8'($urandom);
      r.sub_kind = 2'($urandom);
      r.sub_addr = 16'($urandom);
      r.count = 16'($urandom);
      r.status = code | 8'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 5) r.status = 8'($urandom);
      r.rx_data = 8'($urandom);
      r.tx_data = 8'($urandom);
      send_item(r, 1'b0, '0);
   endtask

   task automatic run_sequence();
      logic [7:0]  plan[$];
      req_type     r;
      logic [1:0]  op;
      logic [1:0]  kind;
      logic [15:0] cnt;
      int          kbytes;
      int          ndata;
      int          p;
      bit          cut;
      bit          rejected;
      op = 2'($urandom_range(0, 3));
      kind = 2'($urandom_range(1, 3));
      p = $urandom_range(0, 99);
      if (p < 80) cnt = 16'($urandom_range(1, 6));
      else if (p < 90) cnt = 16'($urandom_range(7, 40));
      else cnt = 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 99) < 8) begin
         op = $urandom_range(0, 1) ? OP_READ_N : OP_WRITE_N;
         if ($urandom_range(0, 1)) cnt = '0;
         else kind = KIND_NONE;
      end
      rejected = (op == OP_READ_N || op == OP_WRITE_N) && (cnt == '0 || kind == KIND_NONE);
      r.func = FUNC_START;
      r.op = op;
      r.dev_addr = 8'($urandom);
      r.sub_kind = (op == OP_SEND_BYTE || op == OP_RECV_BYTE) ? 2'($urandom) : kind;
      r.sub_addr = 16'($urandom);
      r.count = (op == OP_SEND_BYTE || op == OP_RECV_BYTE) ? 16'($urandom) : cnt;
      r.status = 8'($urandom);
      r.rx_data = 8'($urandom);
      r.tx_data = 8'($urandom);
      send_item(r, 1'b0, '0);

      kbytes = (kind == KIND_TWO_BYTE) ? 2 : 1;
      cut = (cnt > 8);
      ndata = cut ? int'($urandom_range(1, 8)) : int'(cnt);
      if (rejected) begin
         repeat ($urandom_range(0, 2)) plan.push_back(8'($urandom));
      end else begin
         case (op)
            OP_SEND_BYTE: begin
               plan = {ST_START, ST_SLA_W_ACK, ST_DATA_TX_ACK};
            end
            OP_RECV_BYTE: begin
               plan = {ST_START, ST_SLA_R_ACK, ST_DATA_RX_NACK};
            end
            OP_READ_N: begin
               plan.push_back(ST_START);
               plan.push_back(ST_SLA_W_ACK);
               repeat (kbytes) plan.push_back(ST_DATA_TX_ACK);
               plan.push_back(ST_RESTART);
               plan.push_back(ST_SLA_R_ACK);
               repeat (ndata - 1) plan.push_back(ST_DATA_RX_ACK);
               plan.push_back(ST_DATA_RX_NACK);
            end
            default: begin
               plan.push_back(ST_START);
               plan.push_back(ST_SLA_W_ACK);
               repeat (kbytes - 1 + ndata + 1) plan.push_back(ST_DATA_TX_ACK);
            end
         endcase
         if (cut) plan[plan.size() - 1] = pick_error();
      end
      for (int i = 0; i < plan.size(); i++) begin
         if ($urandom_range(0, 99) < 3) begin
            send_event(pick_error());
            break;
         end
         send_event(plan[i]);
      end
   endtask

   task automatic report_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         failures++;
         if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (rsp_due_q.size() == 0) begin
            failures++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: transaction expected none actual %p", $time, rsp_data);
            end
         end else begin
            want = rsp_due_q.pop_front();
            report_field("data_write", 8'(want.data_write), 8'(rsp_data.data_write));
            report_field("data_byte", want.data_byte, rsp_data.data_byte);
            report_field("ctrl_set", 8'(want.ctrl_set), 8'(rsp_data.ctrl_set));
            report_field("ctrl_clear", 8'(want.ctrl_clear), 8'(rsp_data.ctrl_clear));
            report_field("rx_valid", 8'(want.rx_valid), 8'(rsp_data.rx_valid));
            report_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
            report_field("tx_taken", 8'(want.tx_taken), 8'(rsp_data.tx_taken));
            report_field("end_state", 8'(want.end_state), 8'(rsp_data.end_state));
         end
      end
   end

   // The long hold-off is counted here so that the sender keeps offering transactions.
   initial begin
      int burst;
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            rsp_ready <= 1'b1;
            repeat (burst) @(negedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("i2c_master_transaction_sequencer_core: mismatch");
      $finish;
   end

   initial begin
      int  dir_items;
      bit  held;
      bit  paused;
      held = 1'b0;
      paused = 1'b0;

      add_row(mk_event(8'h07, 8'h00, 8'h00), 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 0, END_BUSY));
      add_row(mk_event(ST_START, 8'h00, 8'h00), 1'b1,
              mk_rsp(1, 0, 0, CLR_NEXT, 0, 0, 0, END_BUSY));
      add_row(mk_start(OP_READ_N, 8'h12, KIND_ONE_BYTE, 16'h0000, 16'h0000), 1'b1,
              mk_rsp(0, 0, 0, 0, 0, 0, 0, END_REJECTED));
      add_row(mk_start(OP_WRITE_N, 8'h34, KIND_NONE, 16'hFFFF, 16'hFFFF), 1'b1,
              mk_rsp(0, 0, 0, 0, 0, 0, 0, END_REJECTED));
      add_row(mk_start(OP_SEND_BYTE, 8'hFF, KIND_NONE, 16'h0000, 16'h0000), 1'b1,
              mk_rsp(0, 0, SET_START, CLR_START, 0, 0, 0, END_BUSY));
      add_row(mk_event(ST_START | 8'h07, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_SLA_W_ACK, 8'h00, 8'hA5), 1'b0, '0);
      add_row(mk_event(ST_DATA_TX_ACK, 8'h00, 8'hFF), 1'b0, '0);
      add_row(mk_start(OP_RECV_BYTE, 8'hFF, KIND_EIGHT_X, 16'hFFFF, 16'hFFFF), 1'b0, '0);
      add_row(mk_event(ST_START, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_SLA_R_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_DATA_RX_NACK, 8'hFF, 8'h00), 1'b0, '0);
      add_row(mk_start(OP_READ_N, 8'hF0, KIND_EIGHT_X, 16'hFFFF, 16'hFFFF), 1'b0, '0);
      add_row(mk_event(ST_START, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_SLA_W_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_DATA_TX_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_RESTART, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_SLA_R_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_DATA_RX_ACK, 8'h5A, 8'h00), 1'b0, '0);
      add_row(mk_start(OP_WRITE_N, 8'h00, KIND_TWO_BYTE, 16'h8001, 16'h0001), 1'b0, '0);
      add_row(mk_event(ST_SLA_W_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_DATA_TX_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_DATA_TX_ACK, 8'h00, 8'h3C), 1'b0, '0);
      add_row(mk_event(ST_DATA_TX_ACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_SLA_W_NACK, 8'h00, 8'h00), 1'b0, '0);
      add_row(mk_event(ST_DATA_RX_ACK, 8'h81, 8'h00), 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
      wait_drained();
      dir_items = items_sent;

      while (items_sent < dir_items + RANDOM_ITEMS) begin
         if (!held && items_sent >= dir_items + 120) begin
            hold_off_req = 1'b1;
            held = 1'b1;
         end
         if (!paused && items_sent >= dir_items + 300) begin
            wait_drained();
            paused = 1'b1;
         end
         steady = ($urandom_range(0, 3) == 0);
         run_sequence();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (rsp_due_q.size() != 0) begin
         failures++;
         $display("%0t: %0d transactions expected but never returned", $time, rsp_due_q.size());
      end
      if (failures == 0) begin
         $display("i2c_master_transaction_sequencer_core: match");
      end else begin
         $display("i2c_master_transaction_sequencer_core: mismatch");
      end
      $finish;
   end

endmodule
